FILE: rtl/core/rsc_pkg.sv
// Shared types, constants and helpers of the rotation subsequence counter.
`timescale 1ns / 1ps
package rsc_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int CNT_W       = 30;
  localparam int SYM_W       = 8;
  localparam logic [CNT_W:0] PRIME = 31'd1000000007;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEXT   = 2'd2,
    FUNC_REPORT = 2'd3
  } func_t;

  typedef struct packed {
    logic clear_all;
    logic append;
    logic take_symbol;
    logic load_rot;
    logic row_start;
    logic row_step;
    logic sum_mode;
    logic period_start;
    logic period_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rows_done;
    logic period_done;
  } stat_t;

  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PRIME) s = s - PRIME;
    return s[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/rsc_dpath.sv
// Datapath: pattern store, rotation register, count row memory and accumulator.
`timescale 1ns / 1ps
module rsc_dpath import rsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [SYM_W-1:0] symbol,
  output stat_t            stat,
  output logic [CNT_W-1:0] total,
  output logic             overflow
);

  localparam int ROW_W = MAX_PATTERN * CNT_W;

  logic [SYM_W-1:0] pat [MAX_PATTERN];
  logic [SYM_W-1:0] rot [MAX_PATTERN];
  logic [SYM_W-1:0] rot_next [MAX_PATTERN];
  logic [LEN_W-1:0] len;
  logic             ovf;
  logic [MAX_PATTERN-1:0] row_valid;
  logic [SYM_W-1:0] sym;

  // Row memory: position j+1 of a row sits in slice j; position zero is always one.
  logic [ROW_W-1:0] mem [MAX_PATTERN];
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] new_row;
  logic             rd_valid;
  logic             pending;
  logic [LEN_W-1:0] rd_cnt;
  logic [IDX_W-1:0] wr_row;
  logic [LEN_W-1:0] limit;
  logic             issue;
  logic             wr_en;

  logic [LEN_W-1:0] period;
  logic [LEN_W-1:0] dcnt;
  logic             eq;
  logic             pdone;
  logic [CNT_W-1:0] acc;
  logic [IDX_W-1:0] top_idx;
  logic [CNT_W-1:0] top_val;

  assign limit = cmd.sum_mode ? period : len;
  assign issue = cmd.row_step && (rd_cnt < limit);
  assign wr_en = cmd.row_step && pending && !cmd.sum_mode;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) + LEN_W'(1)) == len || i == MAX_PATTERN - 1) begin
        rot_next[i] = rot[0];
      end else begin
        rot_next[i] = rot[(i + 1) % MAX_PATTERN];
      end
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] below;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      cur = rd_valid ? rdata[j*CNT_W +: CNT_W] : '0;
      if (j == 0) begin
        below = CNT_W'(1);
      end else begin
        below = rd_valid ? rdata[(j-1)*CNT_W +: CNT_W] : '0;
      end
      if (LEN_W'(j) < len && rot[j] == sym) begin
        new_row[j*CNT_W +: CNT_W] = add_mod(cur, below);
      end else begin
        new_row[j*CNT_W +: CNT_W] = cur;
      end
    end
  end

  always_comb begin
    eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len && rot[i] != pat[i]) eq = 1'b0;
    end
  end

  assign pdone   = (dcnt != '0 && eq) || dcnt == len;
  assign top_idx = IDX_W'(len - LEN_W'(1));
  assign top_val = rd_valid ? rdata[top_idx*CNT_W +: CNT_W] : '0;

  assign stat.rows_done   = (rd_cnt == limit) && !pending;
  assign stat.period_done = pdone;

  always_ff @(posedge clk) begin
    if (issue) rdata <= mem[rd_cnt[IDX_W-1:0]];
    if (wr_en) mem[wr_row] <= new_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ovf       <= 1'b0;
      row_valid <= '0;
      pending   <= 1'b0;
      rd_cnt    <= '0;
    end else begin
      if (cmd.clear_all) begin
        len       <= '0;
        ovf       <= 1'b0;
        row_valid <= '0;
      end
      if (cmd.append) begin
        if (len < LEN_W'(MAX_PATTERN)) begin
          len <= len + LEN_W'(1);
        end else begin
          ovf <= 1'b1;
        end
        row_valid <= '0;
      end
      if (cmd.row_start) begin
        rd_cnt  <= '0;
        pending <= 1'b0;
      end else if (cmd.row_step) begin
        pending <= issue;
        if (issue) rd_cnt <= rd_cnt + LEN_W'(1);
      end
      if (wr_en) row_valid[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && len < LEN_W'(MAX_PATTERN)) pat[len[IDX_W-1:0]] <= symbol;
    if (cmd.take_symbol) sym <= symbol;
    if (cmd.row_step && issue) begin
      wr_row   <= rd_cnt[IDX_W-1:0];
      rd_valid <= row_valid[rd_cnt[IDX_W-1:0]];
    end
    if (cmd.load_rot) begin
      rot <= pat;
    end else if (wr_en || (cmd.period_step && !pdone)) begin
      rot <= rot_next;
    end
    if (cmd.period_start) begin
      dcnt <= '0;
    end else if (cmd.period_step) begin
      if (pdone) period <= dcnt;
      else dcnt <= dcnt + LEN_W'(1);
    end
    if (cmd.row_start) begin
      acc <= '0;
    end else if (cmd.row_step && cmd.sum_mode && pending) begin
      acc <= add_mod(acc, top_val);
    end
    if (cmd.load_out) begin
      total    <= acc;
      overflow <= ovf;
    end
  end

endmodule

FILE: rtl/core/rsc_ctrl.sv
// Controller: request decode and sequencing of text update, period search and sum.
`timescale 1ns / 1ps
module rsc_ctrl import rsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  func_t func,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TEXT   = 5'b00010,
    S_PERIOD = 5'b00100,
    S_SUM    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_CLEAR:  cmd.clear_all = 1'b1;
            FUNC_APPEND: cmd.append = 1'b1;
            FUNC_TEXT: begin
              cmd.take_symbol = 1'b1;
              cmd.load_rot    = 1'b1;
              cmd.row_start   = 1'b1;
              state_next      = S_TEXT;
            end
            FUNC_REPORT: begin
              cmd.load_rot     = 1'b1;
              cmd.period_start = 1'b1;
              state_next       = S_PERIOD;
            end
            default: ;
          endcase
        end
      end
      S_TEXT: begin
        cmd.row_step = 1'b1;
        if (stat.rows_done) state_next = S_IDLE;
      end
      S_PERIOD: begin
        cmd.period_step = 1'b1;
        if (stat.period_done) begin
          cmd.row_start = 1'b1;
          state_next    = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_mode = 1'b1;
        cmd.row_step = 1'b1;
        if (stat.rows_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/rotation_subsequence_counter.sv
// Top level of the rotation subsequence counter.
`timescale 1ns / 1ps
// Counts, modulo 1000000007, the subsequence occurrences of every distinct
// rotation of a pattern of up to 32 bytes in a streamed text and reports their
// sum. For a text byte, one row of counts is read from the row memory and
// written back per cycle, and the read of the row memory is registered. For a
// report, the rotation period is found one shift per cycle, then one memory
// row per cycle of the first period rows is added to the total. The result
// waits in an output register, a report that finishes while an earlier result
// still waits holds until that one is taken, and requests of every kind,
// reports too, can be taken while it waits.
module rotation_subsequence_counter import rsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [29:0] total, [30] overflow, [31] zero
);

  cmd_t             cmd;
  stat_t            stat;
  logic [CNT_W-1:0] total;
  logic             overflow;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (func_t'(s_tuser)),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsc_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .symbol   (s_tdata),
    .stat     (stat),
    .total    (total),
    .overflow (overflow)
  );

  assign m_tdata = {1'b0, overflow, total};

endmodule

FILE: rtl/core/rsc_checker.sv
// Port-level assertions for the rotation subsequence counter and their bind.
`timescale 1ns / 1ps
module rsc_port_props import rsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result request dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, m_tdata[29:0]} < PRIME)
    else $error("total not reduced modulo the prime");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31] == 1'b0)
    else $error("padding bit set");

endmodule

bind rotation_subsequence_counter rsc_port_props u_rsc_port_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
